### rtl/core/mbrchk_pkg.sv
// Shared types and constants of the MBR partition table checker.
`timescale 1ns / 1ps
`default_nettype none
package mbrchk_pkg;

	localparam int TableOffset = 446;
	localparam int TableBytes  = 64;
	localparam int LastByte    = 511;
	localparam int SectorBytes = 512;

	localparam logic [7:0] BootFlag  = 8'h80;
	localparam logic [7:0] SysExtChs = 8'd5;
	localparam logic [7:0] SysExtLba = 8'd15;

	// "EFI PART"
	localparam logic [7:0] GptSig [8] = '{8'h45, 8'h46, 8'h49, 8'h20,
		8'h50, 8'h41, 8'h52, 8'h54};

	typedef enum logic [3:0] {
		ST_PART      = 4'd0,
		ST_NONE      = 4'd1,
		ST_BAD_SIZE  = 4'd2,
		ST_GPT       = 4'd3,
		ST_CHS_START = 4'd4,
		ST_CHS_END   = 4'd5,
		ST_LBA_ZERO  = 4'd6,
		ST_TWO_EXT   = 4'd7,
		ST_TWO_BOOT  = 4'd8,
		ST_OVERLAP   = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		S_RX,
		S_EVAL,
		S_READ,
		S_WAIT,
		S_CHECK,
		S_OVL,
		S_EMIT
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  entry_index;
		logic [7:0]  part_type;
		logic [31:0] part_start;
		logic [31:0] sector_count;
		logic        bootable;
		logic        extended_seen;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/mbrchk_if.sv
// Handshake channels of the MBR partition table checker.
`timescale 1ns / 1ps
`default_nettype none
interface mbrchk_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       sector_start;

	modport source (output valid, data_byte, sector_start, input ready);
	modport sink (input valid, data_byte, sector_start, output ready);
endinterface

interface mbrchk_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [1:0]  entry_index;
	logic [7:0]  part_type;
	logic [31:0] part_start;
	logic [31:0] sector_count;
	logic        bootable;
	logic        extended_seen;
	logic        last;

	modport source (output valid, status, entry_index, part_type, part_start, sector_count,
		bootable, extended_seen, last, input ready);
	modport sink (input valid, status, entry_index, part_type, part_start, sector_count,
		bootable, extended_seen, last, output ready);
endinterface

interface mbrchk_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] sector_size;

	modport source (output valid, sector_size, input ready);
	modport sink (input valid, sector_size, output ready);
endinterface
`default_nettype wire

### rtl/core/mbr_partition_table_checker.sv
// MBR partition table checker: byte capture, table memory and entry checker.
// Throughput: one byte item per cycle while a sector streams in, none during evaluation.
// After byte 511: bad size or GPT is reported from evaluation; else each entry's bytes are
// read and checked; a passing plain partition is then checked for overlap with earlier
// slots, and the kept slots are reported. The result register lets the next sector start.
// Reset: no sector in progress, sector size 512; the table RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mbr_partition_table_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mbrchk_byte_if.sink     byte_ch,
	mbrchk_res_if.source    result_ch,
	mbrchk_cfg_if.sink      cfg
);
	import mbrchk_pkg::*;

	state_t state_q, state_d;

	logic [9:0]  pos_q;
	logic        sig_q;
	logic        done_q;
	logic [15:0] size_q;

	// table RAM
	logic [7:0]  mem [TableBytes];
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [9:0]  wr_off;
	logic        rd_en;
	logic [5:0]  rd_addr;
	logic [7:0]  rd_byte_s1;
	logic [3:0]  rd_idx_s1;
	logic        rd_pend_s1;

	// sweep control
	logic [1:0]  ent_q;
	logic [3:0]  byte_q;
	logic [1:0]  slot_q;
	logic [7:0]  ent_bytes_q [16];
	logic [3:0]  kept_q;
	logic        ext_q;
	logic        boot_seen_q;
	logic [32:0] cand_end_q;

	logic [31:0] slot_lba_q [4];
	logic [31:0] slot_cnt_q [4];
	logic [32:0] slot_end_q [4];
	logic [7:0]  slot_sys_q [4];
	logic [3:0]  slot_boot_q;

	logic        out_valid_q;
	result_t     res_q, res_d;
	logic        out_load;
	logic        out_free;

	// input side
	logic        in_fire;
	logic        done_eff;
	logic        sig_eff;
	logic        sig_nxt;
	logic [9:0]  p;

	// entry decode
	logic        e_boot;
	logic [7:0]  e_sys;
	logic [31:0] lba_w;
	logic [31:0] cnt_w;
	logic        e_ext;
	status_t     chk_st;
	logic [32:0] s_w;
	logic [32:0] js_w;
	logic [32:0] je_w;
	logic        ovl;
	logic        later;

	// controls from the next-state block
	logic        sweep_clr;
	logic        advance;
	logic        set_ext;
	logic        ovl_start;
	logic        slot_inc;
	logic        slot_accept;

	assign byte_ch.ready = (state_q == S_RX);
	assign in_fire       = byte_ch.valid && byte_ch.ready;
	assign cfg.ready     = 1'b1;

	assign done_eff = byte_ch.sector_start ? 1'b0 : done_q;
	assign p        = byte_ch.sector_start ? 10'd0 : pos_q;
	assign sig_eff  = byte_ch.sector_start ? 1'b1 : sig_q;
	assign sig_nxt  = sig_eff && !(p < 10'd8 && byte_ch.data_byte != GptSig[p[2:0]]);

	assign wr_off  = p - 10'(TableOffset);
	assign wr_addr = wr_off[5:0];
	assign wr_en   = in_fire && !done_eff && p >= 10'(TableOffset)
		&& p < 10'(TableOffset + TableBytes);
	assign rd_addr = {ent_q, byte_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= byte_ch.data_byte;
		end
		rd_byte_s1 <= mem[rd_addr];
		rd_idx_s1  <= byte_q;
		if (rd_pend_s1) begin
			ent_bytes_q[rd_idx_s1] <= rd_byte_s1;
		end
	end

	assign e_boot = (ent_bytes_q[0] == BootFlag);
	assign e_sys  = ent_bytes_q[4];
	assign lba_w  = {ent_bytes_q[11], ent_bytes_q[10], ent_bytes_q[9], ent_bytes_q[8]};
	assign cnt_w  = {ent_bytes_q[15], ent_bytes_q[14], ent_bytes_q[13], ent_bytes_q[12]};
	assign e_ext  = (e_sys == SysExtChs) || (e_sys == SysExtLba);

	assign s_w  = {1'b0, lba_w};
	assign js_w = {1'b0, slot_lba_q[slot_q]};
	assign je_w = slot_end_q[slot_q];
	assign ovl  = (js_w < s_w && s_w < je_w) || (s_w < js_w && js_w < cand_end_q)
		|| (s_w == js_w);

	assign out_free = !out_valid_q || result_ch.ready;

	always_comb begin
		priority if ((ent_bytes_q[1] | ent_bytes_q[2] | ent_bytes_q[3]) == 8'd0) begin
			chk_st = ST_CHS_START;
		end else if ((ent_bytes_q[5] | ent_bytes_q[6] | ent_bytes_q[7]) == 8'd0) begin
			chk_st = ST_CHS_END;
		end else if (lba_w == 32'd0 || cnt_w == 32'd0) begin
			chk_st = ST_LBA_ZERO;
		end else if (e_ext && ext_q) begin
			chk_st = ST_TWO_EXT;
		end else if (!e_ext && e_boot && boot_seen_q) begin
			chk_st = ST_TWO_BOOT;
		end else begin
			chk_st = ST_PART;
		end
	end

	always_comb begin
		later = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (kept_q[i] && 2'(i) > slot_q) begin
				later = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RX;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_load    = 1'b0;
		rd_en       = 1'b0;
		sweep_clr   = 1'b0;
		advance     = 1'b0;
		set_ext     = 1'b0;
		ovl_start   = 1'b0;
		slot_inc    = 1'b0;
		slot_accept = 1'b0;
		res_d       = '0;
		res_d.status = ST_PART;
		res_d.last   = 1'b1;
		unique case (state_q)
			S_RX: begin
				if (in_fire && !done_eff && p >= 10'(LastByte)) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (size_q != 16'(SectorBytes) || sig_q) begin
					res_d.status = (size_q != 16'(SectorBytes)) ? ST_BAD_SIZE : ST_GPT;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_RX;
					end
				end else begin
					sweep_clr = 1'b1;
					state_d   = S_READ;
				end
			end
			S_READ: begin
				rd_en = 1'b1;
				if (byte_q == 4'd15) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				res_d.entry_index   = ent_q;
				res_d.part_type     = e_sys;
				res_d.part_start    = lba_w;
				res_d.sector_count  = cnt_w;
				res_d.bootable      = e_boot;
				res_d.extended_seen = ext_q;
				res_d.status        = chk_st;
				priority if (e_sys == 8'd0) begin
					advance = 1'b1;
				end else if (chk_st != ST_PART) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_RX;
					end
				end else if (e_ext) begin
					set_ext = 1'b1;
					advance = 1'b1;
				end else begin
					ovl_start = 1'b1;
					state_d   = S_OVL;
				end
			end
			S_OVL: begin
				res_d.entry_index   = ent_q;
				res_d.part_type     = e_sys;
				res_d.part_start    = lba_w;
				res_d.sector_count  = cnt_w;
				res_d.bootable      = e_boot;
				res_d.extended_seen = ext_q;
				res_d.status        = ST_OVERLAP;
				priority if (slot_q == ent_q) begin
					slot_accept = 1'b1;
					advance     = 1'b1;
				end else if (kept_q[slot_q] && ovl) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_RX;
					end
				end else begin
					slot_inc = 1'b1;
				end
			end
			S_EMIT: begin
				res_d.extended_seen = ext_q;
				priority if (kept_q == 4'd0) begin
					res_d.status = ST_NONE;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_RX;
					end
				end else if (!kept_q[slot_q]) begin
					slot_inc = 1'b1;
				end else begin
					res_d.entry_index  = slot_q;
					res_d.part_type    = slot_sys_q[slot_q];
					res_d.part_start   = slot_lba_q[slot_q];
					res_d.sector_count = slot_cnt_q[slot_q];
					res_d.bootable     = slot_boot_q[slot_q];
					res_d.last         = !later;
					if (out_free) begin
						out_load = 1'b1;
						slot_inc = later;
						if (!later) begin
							state_d = S_RX;
						end
					end
				end
			end
			default: begin
				state_d = S_RX;
			end
		endcase
		if (advance) begin
			state_d = (ent_q == 2'd3) ? S_EMIT : S_READ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sig_q       <= 1'b1;
			done_q      <= 1'b1;
			size_q      <= 16'(SectorBytes);
			rd_pend_s1  <= 1'b0;
			ent_q       <= '0;
			byte_q      <= '0;
			slot_q      <= '0;
			kept_q      <= '0;
			ext_q       <= 1'b0;
			boot_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (cfg.valid && cfg.ready) begin
				size_q <= cfg.sector_size;
			end
			if (in_fire && !done_eff) begin
				sig_q  <= sig_nxt;
				done_q <= (p >= 10'(LastByte));
				if (p < 10'(LastByte)) begin
					pos_q <= p + 10'd1;
				end
			end
			if (sweep_clr) begin
				ent_q       <= '0;
				byte_q      <= '0;
				kept_q      <= '0;
				ext_q       <= 1'b0;
				boot_seen_q <= 1'b0;
			end
			if (rd_en) begin
				byte_q <= byte_q + 4'd1;
			end
			if (set_ext) begin
				ext_q <= 1'b1;
			end
			if (ovl_start) begin
				slot_q      <= '0;
				boot_seen_q <= boot_seen_q | e_boot;
			end
			if (slot_inc) begin
				slot_q <= slot_q + 2'd1;
			end
			if (slot_accept) begin
				kept_q[ent_q] <= 1'b1;
			end
			if (advance) begin
				slot_q <= '0;
				byte_q <= '0;
				if (ent_q != 2'd3) begin
					ent_q <= ent_q + 2'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers of the kept slots, the candidate end and the result register
	always_ff @(posedge clk) begin
		if (ovl_start) begin
			cand_end_q <= {1'b0, lba_w} + {1'b0, cnt_w};
		end
		if (slot_accept) begin
			slot_lba_q[ent_q]  <= lba_w;
			slot_cnt_q[ent_q]  <= cnt_w;
			slot_end_q[ent_q]  <= cand_end_q;
			slot_sys_q[ent_q]  <= e_sys;
			slot_boot_q[ent_q] <= e_boot;
		end
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.status        = res_q.status;
	assign result_ch.entry_index   = res_q.entry_index;
	assign result_ch.part_type     = res_q.part_type;
	assign result_ch.part_start    = res_q.part_start;
	assign result_ch.sector_count  = res_q.sector_count;
	assign result_ch.bootable      = res_q.bootable;
	assign result_ch.extended_seen = res_q.extended_seen;
	assign result_ch.last          = res_q.last;

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_RX |-> done_q)
		else $error("evaluation running while a sector is still open");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_PART |-> res_q.last)
		else $error("error or summary item not marked last");

	a_one_boot: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(kept_q & slot_boot_q) <= 1)
		else $error("more than one bootable partition kept");

	a_ovl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OVL |-> slot_q <= ent_q)
		else $error("overlap scan past the current entry");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || result_ch.ready))
		else $error("result register overwritten while full");

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the MBR partition table checker: sector streams against a predictor.
`timescale 1ns / 1ps
module tb;
	import mbrchk_pkg::*;

	localparam int QuietLimit  = 10000;	// longest hold-off is StallHold plus the evaluation
	localparam int DrainCycles = 150;
	localparam int StallHold   = 1500;
	localparam int MaxReports  = 40;

	localparam logic [23:0] ChsA     = 24'h000201;
	localparam logic [23:0] ChsB     = 24'hFE3F07;
	localparam logic [7:0]  SysLinux = 8'h83;
	localparam logic [7:0]  SysNtfs  = 8'h07;

	logic clk = 1'b0;
	logic arst_n;

	mbrchk_byte_if byte_ch();
	mbrchk_res_if  result_ch();
	mbrchk_cfg_if  cfg_ch();

	mbr_partition_table_checker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch),
		.cfg(cfg_ch)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [15:0] size_reg;
	logic [9:0]  cur_pos;
	bit          sig_ok;
	bit          between_sectors;
	logic [7:0]  table_copy [TableBytes];
	result_t     expected_reports [$];

	logic [7:0]  sect [SectorBytes];
	bit          send_gaps = 1'b1;
	bit          recv_gaps = 1'b1;
	int          hold_req = 0;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          quiet = 0;
	int          mismatches = 0;
	bit          failed = 1'b0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] entry_word(int slot, int off);
		int b;
		b = slot * 16 + off;
		return {table_copy[b + 3], table_copy[b + 2], table_copy[b + 1], table_copy[b]};
	endfunction

	function automatic void add_report(status_t st, int idx, logic [7:0] sys, logic [31:0] lba,
			logic [31:0] cnt, bit boot, bit ext, bit fin);
		result_t r;
		r.status        = st;
		r.entry_index   = 2'(idx);
		r.part_type     = sys;
		r.part_start    = lba;
		r.sector_count  = cnt;
		r.bootable      = boot;
		r.extended_seen = ext;
		r.last          = fin;
		expected_reports.push_back(r);
	endfunction

	function automatic void judge_table();
		bit          kept [4];
		bit          ext_seen, boot_seen, boot;
		logic [7:0]  sys;
		logic [31:0] lba, cnt;
		logic [32:0] s_end, o_start, o_end;
		status_t     err;
		int          base, total, k;
		ext_seen  = 0;
		boot_seen = 0;
		total     = 0;
		k         = 0;
		for (int i = 0; i < 4; i++)
			kept[i] = 0;
		if (size_reg != 16'(SectorBytes)) begin
			add_report(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		if (sig_ok) begin
			add_report(ST_GPT, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		for (int i = 0; i < 4; i++) begin
			base = i * 16;
			sys  = table_copy[base + 4];
			boot = table_copy[base] == BootFlag;
			lba  = entry_word(i, 8);
			cnt  = entry_word(i, 12);
			err  = ST_PART;	// no fault yet
			if (sys == 8'h00)
				continue;
			if ({table_copy[base + 1], table_copy[base + 2], table_copy[base + 3]} == 24'd0)
				err = ST_CHS_START;
			else if ({table_copy[base + 5], table_copy[base + 6], table_copy[base + 7]} == 24'd0)
				err = ST_CHS_END;
			else if (lba == 32'd0 || cnt == 32'd0)
				err = ST_LBA_ZERO;
			else if (sys == SysExtChs || sys == SysExtLba) begin
				if (ext_seen)
					err = ST_TWO_EXT;
				else begin
					ext_seen = 1;
					continue;
				end
			end else if (boot && boot_seen)
				err = ST_TWO_BOOT;
			if (err == ST_PART) begin
				if (boot)
					boot_seen = 1;
				s_end = {1'b0, lba} + cnt;
				for (int j = 0; j < i; j++) begin
					if (!kept[j])
						continue;
					o_start = entry_word(j, 8);
					o_end   = o_start + entry_word(j, 12);
					// equal starts count as an overlap too
					if ((o_start < lba && lba < o_end) || (lba < o_start && o_start < s_end) ||
							o_start == lba) begin
						err = ST_OVERLAP;
						break;
					end
				end
			end
			if (err != ST_PART) begin
				add_report(err, i, sys, lba, cnt, boot, ext_seen, 1);
				return;
			end
			kept[i] = 1;
			total++;
		end
		if (total == 0) begin
			add_report(ST_NONE, 0, 0, 0, 0, 0, ext_seen, 1);
			return;
		end
		for (int i = 0; i < 4; i++) begin
			if (!kept[i])
				continue;
			k++;
			add_report(ST_PART, i, table_copy[i * 16 + 4], entry_word(i, 8), entry_word(i, 12),
				table_copy[i * 16] == BootFlag, ext_seen, k == total);
		end
	endfunction

	function automatic void track_byte(logic [7:0] b, bit ss);
		int p;
		if (ss) begin
			cur_pos         = '0;
			between_sectors = 0;
			sig_ok          = 1;
		end
		if (between_sectors)
			return;
		p = cur_pos;
		if (p < 8 && b != GptSig[p])
			sig_ok = 0;
		if (p >= TableOffset && p < TableOffset + TableBytes)
			table_copy[p - TableOffset] = b;
		if (p >= LastByte) begin
			between_sectors = 1;
			judge_table();
			return;
		end
		cur_pos = 10'(p + 1);
	endfunction

	// sector image builders
	function automatic void start_sector();
		for (int i = 0; i < SectorBytes; i++)
			sect[i] = 8'($urandom);
		sect[0] = 8'h00;	// never a GPT header
		for (int i = 0; i < TableBytes; i++)
			sect[TableOffset + i] = 8'h00;
	endfunction

	function automatic void put_entry(int slot, logic [7:0] flag, logic [7:0] sys,
			logic [23:0] chs_lo, logic [23:0] chs_hi, logic [31:0] lba, logic [31:0] cnt);
		int b;
		b = TableOffset + slot * 16;
		sect[b] = flag;
		sect[b + 4] = sys;
		for (int i = 0; i < 3; i++) begin
			sect[b + 1 + i] = chs_lo[8 * i +: 8];
			sect[b + 5 + i] = chs_hi[8 * i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			sect[b + 8 + i]  = lba[8 * i +: 8];
			sect[b + 12 + i] = cnt[8 * i +: 8];
		end
	endfunction

	function automatic void build_random_sector();
		logic [31:0] cursor, prev_lba, lba, cnt;
		logic [7:0]  sys, flag;
		logic [23:0] chs_lo, chs_hi;
		int          pick;
		start_sector();
		sect[0] = 8'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 0; i < 8; i++)
				sect[i] = GptSig[i];
			if ($urandom_range(0, 1) == 1)
				sect[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
		end
		cursor   = $urandom_range(1, 100000);
		prev_lba = cursor;
		for (int s = 0; s < 4; s++) begin
			for (int i = 0; i < 16; i++)
				sect[TableOffset + s * 16 + i] = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				sect[TableOffset + s * 16 + 4] = 8'h00;
				continue;
			end
			if (pick < 30)
				sys = ($urandom_range(0, 1) == 1) ? SysExtChs : SysExtLba;
			else begin
				sys = 8'($urandom_range(1, 255));
				if (sys == SysExtChs || sys == SysExtLba)
					sys = SysLinux;
			end
			pick = $urandom_range(0, 99);
			flag = (pick < 65) ? 8'h00 : (pick < 90) ? BootFlag : 8'($urandom);
			chs_lo = 24'($urandom_range(1, 24'hFFFFFF));
			chs_hi = 24'($urandom_range(1, 24'hFFFFFF));
			pick = $urandom_range(0, 99);
			if (pick < 3)
				chs_lo = '0;
			else if (pick < 6)
				chs_hi = '0;
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				lba    = cursor + $urandom_range(0, 2);
				cnt    = $urandom_range(1, 4096);
				cursor = lba + cnt;
			end else if (pick < 88) begin
				// start at or just past the previous entry's start
				lba = ($urandom_range(0, 1) == 1) ? prev_lba : prev_lba + $urandom_range(0, 8);
				cnt = $urandom_range(1, 64);
			end else if (pick < 93) begin
				lba = ($urandom_range(0, 1) == 1) ? 32'd0 : cursor;
				cnt = (lba == 32'd0) ? 32'($urandom_range(0, 9)) : 32'd0;
			end else begin
				lba = $urandom;
				cnt = $urandom;
			end
			prev_lba = lba;
			put_entry(s, flag, sys, chs_lo, chs_hi, lba, cnt);
		end
	endfunction

	// item senders
	task automatic put_byte(input logic [7:0] b, input bit ss);
		int g;
		g = send_gaps ? gap_len() : 0;
		if (g > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.data_byte    <= b;
		byte_ch.sector_start <= ss;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		track_byte(b, ss);
	endtask

	task automatic release_byte_channel();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sector(input int count = SectorBytes);
		for (int i = 0; i < count; i++)
			put_byte(sect[i], i == 0);
	endtask

	task automatic send_stray_bytes(input int count);
		for (int i = 0; i < count; i++)
			put_byte(8'($urandom), 1'b0);
	endtask

	task automatic drain_reports();
		release_byte_channel();
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_sector_size(input logic [15:0] v);
		drain_reports();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.sector_size <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		size_reg = v;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// directed tests
	task automatic test_reset_state();
		send_stray_bytes(5);	// nothing in progress: ignored
		start_sector();
		put_entry(0, BootFlag, SysLinux, ChsA, ChsB, 32'd2048, 32'd1000);
		put_entry(2, 8'h00, SysNtfs, ChsB, ChsA, 32'd4000, 32'd10);
		send_sector();
	endtask

	task automatic test_table_verdicts();
		start_sector();
		send_sector();
		start_sector();
		put_entry(3, 8'h00, SysExtLba, ChsA, ChsA, 32'd63, 32'd100);
		send_sector();
		start_sector();
		for (int i = 0; i < 8; i++)
			sect[i] = GptSig[i];
		put_entry(0, 8'h00, SysLinux, ChsA, ChsA, 32'd1, 32'd1);
		send_sector();
		sect[7] = GptSig[7] ^ 8'h01;	// one byte off: plain MBR
		send_sector();
	endtask

	task automatic test_entry_faults();
		start_sector();
		put_entry(0, 8'h00, SysLinux, 24'd0, ChsA, 32'd10, 32'd10);
		send_sector();
		start_sector();
		put_entry(0, 8'h00, SysLinux, 24'h010000, ChsA, 32'd10, 32'd10);
		put_entry(1, 8'hFF, 8'hFF, ChsA, 24'h000001, 32'd20, 32'd10);
		put_entry(2, 8'h00, SysNtfs, ChsA, 24'd0, 32'd40, 32'd10);
		send_sector();
		start_sector();
		put_entry(1, 8'h00, SysLinux, ChsA, ChsB, 32'd0, 32'd10);
		send_sector();
		start_sector();
		put_entry(0, 8'h00, SysExtChs, ChsA, ChsB, 32'd10, 32'd0);
		send_sector();
		start_sector();
		put_entry(0, 8'h00, SysExtChs, ChsA, ChsB, 32'd100, 32'd50);
		put_entry(1, 8'h00, SysLinux, ChsA, ChsB, 32'd10, 32'd5);
		put_entry(2, 8'h00, SysExtLba, ChsA, ChsB, 32'd200, 32'd50);
		send_sector();
		start_sector();
		put_entry(0, BootFlag, SysLinux, ChsA, ChsB, 32'd10, 32'd5);
		put_entry(1, 8'hFF, SysNtfs, ChsA, ChsB, 32'd20, 32'd5);
		put_entry(3, BootFlag, SysNtfs, ChsA, ChsB, 32'd30, 32'd5);
		send_sector();
	endtask

	task automatic test_overlap_rules();
		start_sector();
		put_entry(0, 8'h00, SysLinux, ChsA, ChsB, 32'd100, 32'd50);
		put_entry(1, 8'h00, SysLinux, ChsA, ChsB, 32'd120, 32'd10);
		send_sector();
		start_sector();
		put_entry(0, 8'h00, SysLinux, ChsA, ChsB, 32'd200, 32'd10);
		put_entry(2, 8'h00, SysLinux, ChsA, ChsB, 32'd150, 32'd60);
		send_sector();
		start_sector();
		put_entry(1, 8'h00, SysLinux, ChsA, ChsB, 32'd300, 32'd5);
		put_entry(3, 8'h00, SysNtfs, ChsA, ChsB, 32'd300, 32'd1);
		send_sector();
		// touching ranges are fine; an extended entry is never compared
		start_sector();
		put_entry(0, 8'h00, SysLinux, ChsA, ChsB, 32'd100, 32'd50);
		put_entry(1, BootFlag, SysLinux, ChsA, ChsB, 32'd150, 32'd50);
		put_entry(2, 8'h00, SysExtLba, ChsA, ChsB, 32'd100, 32'd400);
		put_entry(3, 8'h00, SysNtfs, ChsA, ChsB, 32'd500, 32'd1);
		send_sector();
		// ends past 2^32 must not wrap
		start_sector();
		put_entry(0, BootFlag, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		put_entry(1, 8'hFF, SysLinux, ChsA, ChsB, 32'hFFFF_FFFE, 32'd1);
		send_sector();
		start_sector();
		put_entry(0, 8'h00, SysLinux, ChsA, ChsB, 32'hFFFF_FFFF, 32'd1);
		put_entry(1, 8'h00, SysLinux, ChsA, ChsB, 32'd1, 32'hFFFF_FFFF);
		send_sector();
	endtask

	task automatic test_restart_and_idle();
		start_sector();
		put_entry(0, 8'h00, SysLinux, ChsA, ChsB, 32'd64, 32'd64);
		send_sector(100);
		start_sector();
		put_entry(1, BootFlag, SysNtfs, ChsA, ChsB, 32'd900, 32'd9);
		send_sector(LastByte);	// cut one byte short of evaluation
		put_entry(2, 8'h00, SysLinux, ChsA, ChsB, 32'd2000, 32'd9);
		send_sector();
		send_stray_bytes(20);
	endtask

	task automatic test_sector_size_reg();
		write_sector_size(16'd0);
		start_sector();
		put_entry(0, 8'h00, SysLinux, ChsA, ChsB, 32'd64, 32'd64);
		send_sector();
		write_sector_size(16'hFFFF);
		for (int i = 0; i < 8; i++)
			sect[i] = GptSig[i];
		send_sector();
		write_sector_size(16'(SectorBytes + 1));
		send_sector();
		write_sector_size(16'(SectorBytes - 1));
		send_sector();
		write_sector_size(16'(SectorBytes));
		send_sector();
	endtask

	task automatic test_random_tables();
		for (int n = 0; n < 48; n++) begin
			if (n == 20)
				write_sector_size(16'($urandom_range(SectorBytes + 1, 65535)));
			if (n == 24)
				write_sector_size(16'(SectorBytes));
			send_gaps = $urandom_range(0, 3) != 0;
			recv_gaps = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) == 0) begin
				build_random_sector();
				send_sector($urandom_range(1, LastByte));
			end
			build_random_sector();
			send_sector();
			if ($urandom_range(0, 9) == 0)
				send_stray_bytes($urandom_range(1, 6));
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// result side held off while full tables keep streaming in
	task automatic test_output_stall();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		hold_req  = StallHold;
		for (int n = 0; n < 3; n++) begin
			start_sector();
			put_entry(0, BootFlag, SysLinux, ChsA, ChsB, 32'd1000, 32'd999);
			for (int s = 1; s < 4; s++)
				put_entry(s, 8'h00, SysNtfs, ChsA, ChsB, 32'(1000 * (s + 1)), 32'd999);
			send_sector();
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// result receiver
	always @(posedge clk) begin
		if (hold_req != 0 && !hold_taken) begin
			hold_left  = hold_req;
			hold_taken = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
			stall_left = gap_len();
			result_ch.ready <= 1'b0;
		end else
			result_ch.ready <= 1'b1;
	end

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			failed = 1'b1;
			mismatches++;
			if (mismatches <= MaxReports)
				$display("%0t: %s expected %h actual %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_reports.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= MaxReports)
					$display("%0t: unexpected result, status expected none actual %h", $time,
						result_ch.status);
			end else begin
				want = expected_reports.pop_front();
				check_field("status", 32'(want.status), 32'(result_ch.status));
				check_field("entry_index", 32'(want.entry_index), 32'(result_ch.entry_index));
				check_field("part_type", 32'(want.part_type), 32'(result_ch.part_type));
				check_field("part_start", want.part_start, result_ch.part_start);
				check_field("sector_count", want.sector_count, result_ch.sector_count);
				check_field("bootable", 32'(want.bootable), 32'(result_ch.bootable));
				check_field("extended_seen", 32'(want.extended_seen),
					32'(result_ch.extended_seen));
				check_field("last", 32'(want.last), 32'(result_ch.last));
			end
		end
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QuietLimit) begin
			$display("%0t: no progress, %0d results outstanding", $time,
				expected_reports.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		size_reg        = 16'(SectorBytes);
		cur_pos         = '0;
		sig_ok          = 1'b1;
		between_sectors = 1'b1;
		arst_n               <= 1'b0;
		byte_ch.valid        <= 1'b0;
		byte_ch.data_byte    <= 8'h00;
		byte_ch.sector_start <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.sector_size   <= 16'(SectorBytes);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_table_verdicts();
		test_entry_faults();
		test_overlap_rules();
		test_restart_and_idle();
		test_sector_size_reg();
		test_random_tables();
		test_output_stall();

		drain_reports();
		if (failed || expected_reports.size() != 0)
			$display("Regression FAIL");
		else
			$display("Regression PASS");
		$finish;
	end
endmodule

### files.f
rtl/core/mbrchk_pkg.sv
rtl/core/mbrchk_if.sv
rtl/core/mbr_partition_table_checker.sv
bench/tb.sv
